FILE: rtl/u8cpi_pkg.sv
// Shared types and constants for the UTF-8 codepoint-at-index block.
package u8cpi_pkg;

  localparam int TARGET_W = 20;
  localparam int CP_W     = 21;
  localparam int OFF_W    = 20;

  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_NUL   = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_CONT  = 3'd5,
    CLS_BAD   = 3'd6
  } cls_t;

  typedef enum logic {
    PH_SCAN = 1'b0,
    PH_DONE = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [CP_W-1:0]     codepoint;
    logic [OFF_W-1:0]    char_offset;
  } out_t;

  typedef struct packed {
    cls_t       cls;
    logic [6:0] value;
    logic       last;
  } token_t;

endpackage

FILE: rtl/u8cpi_fifo.sv
// Small register-based FIFO used between the front, back and result port.
module u8cpi_fifo import u8cpi_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/u8cpi_front.sv
// Front end: accepts raw bytes and classifies them into decode tokens.
module u8cpi_front import u8cpi_pkg::*; (
  input  logic   push,
  input  in_t    in_item,
  output logic   tok_push,
  output token_t tok
);

  always_comb begin
    tok.last  = in_item.last_byte;
    tok.value = '0;
    if (in_item.data_byte == 8'h00) begin
      tok.cls = CLS_NUL;
    end else if (in_item.data_byte[7] == 1'b0) begin
      tok.cls   = CLS_ASCII;
      tok.value = in_item.data_byte[6:0];
    end else if (in_item.data_byte[7:6] == 2'b10) begin
      tok.cls   = CLS_CONT;
      tok.value = {1'b0, in_item.data_byte[5:0]};
    end else if (in_item.data_byte[7:5] == 3'b110) begin
      tok.cls   = CLS_LEAD2;
      tok.value = {2'b00, in_item.data_byte[4:0]};
    end else if (in_item.data_byte[7:4] == 4'b1110) begin
      tok.cls   = CLS_LEAD3;
      tok.value = {3'b000, in_item.data_byte[3:0]};
    end else if (in_item.data_byte[7:3] == 5'b11110) begin
      tok.cls   = CLS_LEAD4;
      tok.value = {4'b0000, in_item.data_byte[2:0]};
    end else begin
      tok.cls = CLS_BAD;
    end
  end

  assign tok_push = push;

endmodule

FILE: rtl/u8cpi_back.sv
// Back end: runs the decode state, counts characters and bytes, emits results.
module u8cpi_back import u8cpi_pkg::*; #(
  parameter int INDEX_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_empty,
  input  token_t              tok,
  output logic                tok_pop,
  input  logic                res_full,
  output logic                res_push,
  output out_t                res,
  input  logic [TARGET_W-1:0] target
);

  localparam int CMP_W = (INDEX_BITS > TARGET_W) ? INDEX_BITS : TARGET_W;

  phase_t                phase;
  phase_t                phase_next;
  logic [1:0]            cont_left;
  logic [1:0]            cont_left_next;
  logic [CP_W-1:0]       accumulator;
  logic [CP_W-1:0]       accumulator_next;
  logic [INDEX_BITS-1:0] char_count;
  logic [INDEX_BITS-1:0] char_count_next;
  logic [INDEX_BITS-1:0] byte_count;
  logic [INDEX_BITS-1:0] byte_count_next;
  logic [INDEX_BITS-1:0] lead_offset;
  logic [INDEX_BITS-1:0] lead_offset_next;

  logic            emit;
  logic            clear;
  logic            complete;
  logic [CP_W-1:0] acc_c;
  logic [CMP_W-1:0] lead_ext;

  assign tok_pop = !tok_empty && !res_full;

  always_comb begin
    phase_next       = phase;
    cont_left_next   = cont_left;
    accumulator_next = accumulator;
    char_count_next  = char_count;
    byte_count_next  = byte_count;
    lead_offset_next = lead_offset;
    emit             = 1'b0;
    clear            = 1'b0;
    complete         = 1'b0;
    acc_c            = accumulator;
    lead_ext         = '0;
    res.status       = ST_NOT_FOUND;
    res.codepoint    = '0;
    res.char_offset  = '0;

    if (tok_pop) begin
      if (phase == PH_DONE) begin
        clear = tok.last;
      end else begin
        byte_count_next = byte_count + 1'b1;
        if (cont_left == 2'd0) begin
          unique case (tok.cls)
            CLS_NUL: begin
              emit       = 1'b1;
              res.status = ST_NOT_FOUND;
            end
            CLS_ASCII: begin
              lead_offset_next = byte_count;
              acc_c            = CP_W'(tok.value);
              complete         = 1'b1;
            end
            CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
              lead_offset_next = byte_count;
              accumulator_next = CP_W'(tok.value);
              unique case (tok.cls)
                CLS_LEAD2: cont_left_next = 2'd1;
                CLS_LEAD3: cont_left_next = 2'd2;
                default:   cont_left_next = 2'd3;
              endcase
              if (tok.last) begin
                emit       = 1'b1;
                res.status = ST_INVALID;
              end
            end
            default: begin
              emit       = 1'b1;
              res.status = ST_INVALID;
            end
          endcase
        end else if (tok.cls != CLS_CONT) begin
          emit       = 1'b1;
          res.status = ST_INVALID;
        end else begin
          acc_c          = {accumulator[CP_W-7:0], tok.value[5:0]};
          cont_left_next = cont_left - 1'b1;
          if (cont_left == 2'd1) begin
            complete = 1'b1;
          end else begin
            accumulator_next = acc_c;
            if (tok.last) begin
              emit       = 1'b1;
              res.status = ST_INVALID;
            end
          end
        end

        if (complete) begin
          accumulator_next = acc_c;
          lead_ext         = CMP_W'(lead_offset_next);
          if (CMP_W'(char_count) == CMP_W'(target)) begin
            emit = 1'b1;
            if (acc_c > CP_MAX || (acc_c >= SURR_LO && acc_c <= SURR_HI)) begin
              res.status = ST_INVALID;
            end else begin
              res.status      = ST_FOUND;
              res.codepoint   = acc_c;
              res.char_offset = lead_ext[OFF_W-1:0];
            end
          end else begin
            char_count_next  = char_count + 1'b1;
            accumulator_next = '0;
            if (tok.last) begin
              emit       = 1'b1;
              res.status = ST_NOT_FOUND;
            end
          end
        end
      end

      if (emit && !tok.last) begin
        phase_next = PH_DONE;
      end
      if (clear || (emit && tok.last)) begin
        phase_next       = PH_SCAN;
        cont_left_next   = '0;
        accumulator_next = '0;
        char_count_next  = '0;
        byte_count_next  = '0;
        lead_offset_next = '0;
      end
    end
  end

  assign res_push = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SCAN;
      cont_left   <= '0;
      accumulator <= '0;
      char_count  <= '0;
      byte_count  <= '0;
      lead_offset <= '0;
    end else begin
      phase       <= phase_next;
      cont_left   <= cont_left_next;
      accumulator <= accumulator_next;
      char_count  <= char_count_next;
      byte_count  <= byte_count_next;
      lead_offset <= lead_offset_next;
    end
  end

endmodule

FILE: rtl/utf8_codepoint_at_index.sv
// Top level of the UTF-8 codepoint-at-index finder.
//
// Input channel: push a byte with its last_byte flag while full is low; one
// byte per cycle is taken. Bytes are classified at the front and queued to
// the back end, which decodes one token per cycle while the result queue is
// not full and updates the counters. Result channel: while empty is low,
// result holds the oldest result; pop takes it. Each string gives one result
// (found, not found or invalid); bytes after a result are dropped until the
// final byte of the buffer. The byte that ends a string is first registered
// in the token queue; the back end then decodes it and writes the result
// queue, which registers the result onto the result ports, from where it can
// be popped. Throughput is one byte per cycle while the result queue has room.
// When the receiver stalls, the result queue fills, the back end holds, and
// the token queue fills until full rises; no byte or result is lost.
// cfg_we writes target_index from cfg_data; write only while the block is
// idle. Reset clears both queues, the decode state, the counters and the
// target index.
module utf8_codepoint_at_index import u8cpi_pkg::*; #(
  parameter int INDEX_BITS  = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  in_t                 in_item,
  output logic                empty,
  input  logic                pop,
  output out_t                result,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_data
);

  localparam int RES_DEPTH = 2;

  logic [TARGET_W-1:0] target_index;
  logic                tok_push;
  token_t              tok_in;
  logic                tok_empty;
  logic                tok_pop;
  logic [$bits(token_t)-1:0] tok_raw;
  logic                res_full;
  logic                res_push;
  out_t                res;
  logic [$bits(out_t)-1:0] res_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_index <= '0;
    end else if (cfg_we) begin
      target_index <= cfg_data;
    end
  end

  u8cpi_front u_front (
    .push     (push),
    .in_item  (in_item),
    .tok_push (tok_push),
    .tok      (tok_in)
  );

  u8cpi_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push  (tok_push),
    .wdata (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .rdata (tok_raw),
    .empty (tok_empty)
  );

  u8cpi_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (tok_empty),
    .tok       (token_t'(tok_raw)),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .target    (target_index)
  );

  u8cpi_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_raw),
    .empty (empty)
  );

  assign result = out_t'(res_raw);

endmodule

FILE: tb/u8cpi_lookup_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard: decodes the accepted byte stream and checks every lookup result.
module u8cpi_lookup_scoreboard import u8cpi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  in_t                 in_item,
  input  logic                empty,
  input  logic                pop,
  input  out_t                result,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_data,
  output int                  fail_count,
  output int                  awaited
);

  localparam int REPORT_LIMIT = 10;

  phase_t              phase;
  logic [1:0]          cont_left;
  logic [CP_W-1:0]     acc;
  logic [OFF_W-1:0]    char_cnt;
  logic [OFF_W-1:0]    byte_cnt;
  logic [OFF_W-1:0]    lead_off;
  logic [TARGET_W-1:0] target;
  out_t                lookups_q[$];
  int                  results_seen;

  function automatic void restart_scan();
    phase     = PH_SCAN;
    cont_left = '0;
    acc       = '0;
    char_cnt  = '0;
    byte_cnt  = '0;
    lead_off  = '0;
  endfunction

  function automatic void close_string(status_t st, logic [CP_W-1:0] cp,
                                       logic [OFF_W-1:0] off, logic last);
    out_t r;
    r.status      = st;
    r.codepoint   = cp;
    r.char_offset = off;
    lookups_q.push_back(r);
    if (last) restart_scan();
    else phase = PH_DONE;
  endfunction

  function automatic void end_char(logic last);
    if (char_cnt == target) begin
      if (acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
        close_string(ST_INVALID, '0, '0, last);
      end else begin
        close_string(ST_FOUND, acc, lead_off, last);
      end
    end else begin
      char_cnt = char_cnt + 1'b1;
      acc      = '0;
      if (last) close_string(ST_NOT_FOUND, '0, '0, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [OFF_W-1:0] here;
    if (phase == PH_DONE) begin
      if (last) restart_scan();
      return;
    end
    here     = byte_cnt;
    byte_cnt = byte_cnt + 1'b1;
    if (cont_left == 2'd0) begin
      if (b == 8'h00) begin
        close_string(ST_NOT_FOUND, '0, '0, last);
        return;
      end
      lead_off = here;
      if (b[7] == 1'b0) begin
        acc = CP_W'(b);
        end_char(last);
        return;
      end
      if (b[7:5] == 3'b110) begin
        acc       = CP_W'(b[4:0]);
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc       = CP_W'(b[3:0]);
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc       = CP_W'(b[2:0]);
        cont_left = 2'd3;
      end else begin
        close_string(ST_INVALID, '0, '0, last);
        return;
      end
      if (last) close_string(ST_INVALID, '0, '0, 1'b1);
      return;
    end
    if (b[7:6] != 2'b10) begin
      close_string(ST_INVALID, '0, '0, last);
      return;
    end
    acc       = {acc[CP_W-7:0], b[5:0]};
    cont_left = cont_left - 1'b1;
    if (cont_left == 2'd0) end_char(last);
    else if (last) close_string(ST_INVALID, '0, '0, 1'b1);
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    results_seen++;
    if (lookups_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result %0d: none expected, got status %0d cp %h off %0d",
                 results_seen, got.status, got.codepoint, got.char_offset);
      return;
    end
    want = lookups_q.pop_front();
    if (got.status !== want.status || got.codepoint !== want.codepoint ||
        got.char_offset !== want.char_offset) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result %0d: expected status %0d cp %h off %0d, got status %0d cp %h off %0d",
                 results_seen, want.status, want.codepoint, want.char_offset,
                 got.status, got.codepoint, got.char_offset);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      target = '0;
      restart_scan();
      lookups_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) target = cfg_data;
      if (push && !full) decode_byte(in_item.data_byte, in_item.last_byte);
      if (pop && !empty) check_result(result);
    end
    awaited = lookups_q.size();
  end

endmodule

FILE: tb/utf8_codepoint_at_index_test.sv
`timescale 1ns / 100ps
// Testbench top: byte-string stimulus, result draining, watchdog and verdict.
module utf8_codepoint_at_index_test;
  import u8cpi_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 12;
  localparam int PHASE_BYTES = 75;
  localparam int PHASES      = 7;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                push     = 1'b0;
  logic                pop      = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [TARGET_W-1:0] cfg_data = '0;
  in_t                 in_item  = '0;
  logic                full;
  logic                empty;
  out_t                result;

  int         fail_count;
  int         awaited;
  int         idle_cycles = 0;
  int         stall_left  = 0;
  int         reach       = 0;
  bit         calm        = 1'b0;
  logic [7:0] text_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_codepoint_at_index u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  u8cpi_lookup_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      pop <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 24)
        stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("utf8_codepoint_at_index_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int idle_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    in_item.data_byte <= b;
    in_item.last_byte <= last;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) put_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic hold_for_results();
    push <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic set_target(input logic [TARGET_W-1:0] value);
    hold_for_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    reach = (value <= 12) ? int'(value) : 6;
  endtask

  function automatic int natural_width(logic [CP_W-1:0] cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  function automatic void add_char(logic [CP_W-1:0] cp, int width);
    case (width)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_random_char();
    int              pick;
    int              width;
    logic [CP_W-1:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 38) cp = CP_W'($urandom_range(1, 'h7F));
    else if (pick < 58) cp = CP_W'($urandom_range('h80, 'h7FF));
    else if (pick < 76) cp = CP_W'($urandom_range('h800, 'hFFFF));
    else if (pick < 80) cp = CP_W'($urandom_range('hD800, 'hDFFF));
    else if (pick < 94) cp = CP_W'($urandom_range('h10000, 'h10FFFF));
    else cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
    width = natural_width(cp);
    if (width < 4 && $urandom_range(0, 24) == 0) width++;
    add_char(cp, width);
  endfunction

  // Returns 1 when the broken sequence has to close the buffer (cut-off case).
  function automatic bit add_broken();
    int kind;
    int len;
    int good;
    kind = $urandom_range(0, 3);
    case (kind)
      0: text_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range('h80, 'hBF))
                                                          : 8'($urandom_range('hF8, 'hFF)));
      1, 2: begin
        len = $urandom_range(1, 3);
        case (len)
          1:       text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          2:       text_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          default: text_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        good = $urandom_range(0, len - 1);
        repeat (good) text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        if (kind == 2) return 1'b1;
        text_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 'h7F))
                                                         : 8'($urandom_range('hC0, 'hFF)));
      end
      default: text_bytes.push_back(8'h00);
    endcase
    return 1'b0;
  endfunction

  function automatic void build_text();
    int mode;
    int n;
    int cut_at;
    bit cut;
    text_bytes.delete();
    cut  = 1'b0;
    mode = $urandom_range(0, 99);
    n    = $urandom_range(reach / 2, reach + 4);
    if (mode < 70) begin
      repeat (n) add_random_char();
      if ($urandom_range(0, 4) == 0) text_bytes.push_back(8'h00);
    end else if (mode < 88) begin
      cut_at = $urandom_range(0, n);
      for (int i = 0; i <= n && !cut; i++) begin
        if (i == cut_at) cut = add_broken();
        if (i < n && !cut) add_random_char();
      end
    end else begin
      repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (!cut && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
    if (text_bytes.size() == 0) add_random_char();
  endfunction

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    text_bytes = '{8'h41};                      send_text();
    text_bytes = '{8'h00};                      send_text();
    text_bytes = '{8'h7F};                      send_text();
    text_bytes = '{8'h80};                      send_text();
    text_bytes = '{8'hFF};                      send_text();
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text();
    text_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; send_text();
    text_bytes = '{8'hED, 8'hA0, 8'h80};        send_text();
    text_bytes = '{8'hC3};                      send_text();
    text_bytes = '{8'hC3, 8'h41};               send_text();
    text_bytes = '{8'hE2, 8'h00};               send_text();
    text_bytes = '{8'h41, 8'h42};               send_text();
    text_bytes = '{8'hC0, 8'h80};               send_text();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_target(20'd1);
        1:       set_target({TARGET_W{1'b1}});
        2:       set_target('0);
        3:       set_target(20'd3);
        4:       set_target(TARGET_W'($urandom_range(0, 12)));
        5:       set_target(20'd6);
        default: set_target(TARGET_W'($urandom()));
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        calm = ($urandom_range(0, 7) == 0);
        build_text();
        send_text();
        sent += text_bytes.size();
        if ($urandom_range(0, 19) == 0) hold_for_results();
      end
    end

    calm = 1'b0;
    hold_for_results();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("utf8_codepoint_at_index_test OK");
    end else begin
      $display("utf8_codepoint_at_index_test NOT OK");
    end
    $finish;
  end

endmodule
